// ----- sv/llm_pkg.sv -----
`default_nettype none

package llm_pkg;

    // Field and state widths.
    localparam int TIME_W = 32;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 48;
    localparam int SC_W   = 16;
    localparam int LAT_W  = 20;
    localparam int TGT_W  = 20;
    localparam int AVG_W  = 24;
    localparam int RATE_W = 32;

    // Largest gap in seconds that is still decayed rather than cleared.
    localparam int STALE_LIMIT_S = 8;
    localparam int STEP_W        = $clog2(STALE_LIMIT_S + 1);

    // Divider widths: the widest numerator is the event and latency product, shifted left by two bits.
    localparam int PROD_W = CNT_W + LAT_W;
    localparam int NUM_W  = PROD_W + 2;
    localparam int QUO_W  = SUM_W;
    localparam int DEN_W  = 64;
    localparam int DCNT_W = 6;

    localparam logic [DCNT_W-1:0] CAND_BITS  = DCNT_W'(QUO_W);
    localparam logic [DCNT_W-1:0] RATIO_BITS = DCNT_W'(AVG_W);

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic REG_TARGET_AVG  = 1'b0;
    localparam logic REG_TARGET_PEAK = 1'b1;

    // Item kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [1:0] {
        DIV_CAND = 2'd0,
        DIV_AVG  = 2'd1,
        DIV_PEAK = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic [TGT_W-1:0] target_avg;
        logic [TGT_W-1:0] target_peak;
    } llm_cfg_t;

    typedef struct packed {
        logic     in_ready;
        logic     time_update;
        logic     decay_step;
        logic     add_samples;
        logic     mul;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_div;
        logic     load_out;
    } llm_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic kind;
        logic steps_zero;
        logic count_zero;
        logic le_zero;
        logic div_done;
        logic out_free;
    } llm_sts_t;

endpackage

`default_nettype wire

// ----- sv/llm_if.sv -----
`default_nettype none

interface llm_in_if;
    import llm_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [TIME_W-1:0] now_s;
    logic [SC_W-1:0]   sample_count;
    logic [LAT_W-1:0]  latency_ms;

    modport source (output valid, kind, now_s, sample_count, latency_ms, input ready);
    modport sink   (input valid, kind, now_s, sample_count, latency_ms, output ready);
endinterface

interface llm_out_if;
    import llm_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] rate;
    logic [AVG_W-1:0]  avg_latency_ms;
    logic [AVG_W-1:0]  peak_latency_ms;
    logic              overloaded;

    modport source (output valid, rate, avg_latency_ms, peak_latency_ms, overloaded,
                    input ready);
    modport sink   (input valid, rate, avg_latency_ms, peak_latency_ms, overloaded,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/llm_cfg.sv -----
`default_nettype none

module llm_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [llm_pkg::APB_AW-1:0]     paddr,
    input  wire logic [llm_pkg::APB_DW-1:0]     pwdata,
    output logic      [llm_pkg::APB_DW-1:0]     prdata,
    output logic                                pready,
    output llm_pkg::llm_cfg_t                   cfg
);
    import llm_pkg::*;

    logic [TGT_W-1:0] target_avg_reg;
    logic [TGT_W-1:0] target_avg_next;
    logic [TGT_W-1:0] target_peak_reg;
    logic [TGT_W-1:0] target_peak_next;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[REG_SEL_BIT];

    always_comb
    begin
        target_avg_next  = target_avg_reg;
        target_peak_next = target_peak_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_TARGET_AVG:  target_avg_next  = pwdata[TGT_W-1:0];
                REG_TARGET_PEAK: target_peak_next = pwdata[TGT_W-1:0];
                default:         target_avg_next  = target_avg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TARGET_AVG:  prdata = APB_DW'(target_avg_reg);
            REG_TARGET_PEAK: prdata = APB_DW'(target_peak_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_avg_reg  <= '0;
            target_peak_reg <= '0;
        end
        else
        begin
            target_avg_reg  <= target_avg_next;
            target_peak_reg <= target_peak_next;
        end
    end

    assign cfg.target_avg  = target_avg_reg;
    assign cfg.target_peak = target_peak_reg;

endmodule

`default_nettype wire

// ----- sv/llm_div.sv -----
`default_nettype none

module llm_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [llm_pkg::NUM_W-1:0]      num,
    input  wire logic [llm_pkg::DEN_W-1:0]      den,
    input  wire logic [llm_pkg::DCNT_W-1:0]     nbits,
    output logic                                done,
    output logic      [llm_pkg::QUO_W-1:0]      quo,
    output logic                                ovf
);
    import llm_pkg::*;

    // The divisor arrives already shifted up by nbits. A check step first tests
    // whether the quotient fits in nbits; after that one quotient bit is
    // resolved per cycle by restoring division.
    logic              busy_reg;
    logic              busy_next;
    logic              chk_reg;
    logic              chk_next;
    logic              done_reg;
    logic              done_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] cnt_next;
    logic [NUM_W-1:0]  r_reg;
    logic [NUM_W-1:0]  r_next;
    logic [DEN_W-1:0]  d_reg;
    logic [DEN_W-1:0]  d_next;
    logic [QUO_W-1:0]  q_reg;
    logic [QUO_W-1:0]  q_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [DEN_W-1:0]  r_ext;
    logic [DEN_W-1:0]  diff;
    logic              ge;

    assign r_ext = DEN_W'(r_reg);
    assign ge    = r_ext >= d_reg;
    assign diff  = r_ext - d_reg;

    always_comb
    begin
        busy_next = busy_reg;
        chk_next  = chk_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            chk_next  = 1'b1;
            cnt_next  = nbits;
            r_next    = num;
            d_next    = den;
            q_next    = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            if (chk_reg)
            begin
                if (ge)
                begin
                    ovf_next  = 1'b1;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    d_next   = d_reg >> 1;
                    chk_next = 1'b0;
                end
            end
            else
            begin
                if (ge)
                begin
                    r_next = diff[NUM_W-1:0];
                end
                q_next   = {q_reg[QUO_W-2:0], ge};
                d_next   = d_reg >> 1;
                cnt_next = cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            chk_reg  <= chk_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

// ----- sv/llm_dp.sv -----
`default_nettype none

module llm_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    llm_in_if.sink                 in_ch,
    llm_out_if.source              out_ch,
    input  wire llm_pkg::llm_cfg_t cfg,
    input  wire llm_pkg::llm_cmd_t cmd,
    output llm_pkg::llm_sts_t      sts
);
    import llm_pkg::*;

    // Captured item.
    logic              kind_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SC_W-1:0]   count_reg;
    logic [LAT_W-1:0]  lat_reg;

    // Running totals.
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    logic [CNT_W-1:0]  ev_reg;
    logic [CNT_W-1:0]  ev_next;
    logic [CNT_W-1:0]  le_reg;
    logic [CNT_W-1:0]  le_next;
    logic [SUM_W-1:0]  avg_reg;
    logic [SUM_W-1:0]  avg_next;
    logic [SUM_W-1:0]  peak_reg;
    logic [SUM_W-1:0]  peak_next;

    // Working registers.
    logic [STEP_W-1:0] steps_reg;
    logic [STEP_W-1:0] steps_next;
    logic [PROD_W-1:0] prod_reg;
    logic [AVG_W-1:0]  avg_q_reg;
    logic              avg_ovf_reg;
    logic [AVG_W-1:0]  peak_q_reg;
    logic              peak_ovf_reg;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [RATE_W-1:0] rate_reg;
    logic [AVG_W-1:0]  avg_out_reg;
    logic [AVG_W-1:0]  peak_out_reg;
    logic              over_reg;

    logic              accept;
    logic              same_time;
    logic              stale;
    logic [TIME_W:0]   last_plus;
    logic [TIME_W-1:0] diff_s;
    logic [CNT_W+1:0]  ev_round;
    logic [CNT_W+1:0]  le_round;
    logic [CNT_W:0]    ev_sum;
    logic [CNT_W:0]    le_sum;
    logic [SUM_W:0]    avg_sum;
    logic [SUM_W:0]    peak_sum;
    logic [CNT_W-1:0]  ev_add;
    logic [CNT_W-1:0]  le_add;
    logic [SUM_W-1:0]  avg_add;
    logic [SUM_W-1:0]  peak_add;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  cand;
    logic              le_zero;

    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic              div_ovf;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [DCNT_W-1:0] div_bits;

    logic [AVG_W-1:0]  avg_res;
    logic [AVG_W-1:0]  peak_res;
    logic              over_avg;
    logic              over_peak;

    assign accept      = cmd.in_ready & in_ch.valid;
    assign in_ch.ready = cmd.in_ready;

    // Time bookkeeping.
    assign last_plus = {1'b0, last_reg} + (TIME_W+1)'(STALE_LIMIT_S);
    assign same_time = now_reg == last_reg;
    assign stale     = (now_reg < last_reg) || ({1'b0, now_reg} > last_plus);
    assign diff_s    = now_reg - last_reg;

    // Event counts lose the ceiling of a quarter, sums the floor.
    assign ev_round = {2'b00, ev_reg} + (CNT_W+2)'(3);
    assign le_round = {2'b00, le_reg} + (CNT_W+2)'(3);

    assign ev_sum   = {1'b0, ev_reg} + (CNT_W+1)'(count_reg);
    assign le_sum   = {1'b0, le_reg} + (CNT_W+1)'(count_reg);
    assign avg_sum  = {1'b0, avg_reg} + (SUM_W+1)'(lat_reg);
    assign peak_sum = {1'b0, peak_reg} + (SUM_W+1)'(lat_reg);
    assign ev_add   = ev_sum[CNT_W]   ? '1 : ev_sum[CNT_W-1:0];
    assign le_add   = le_sum[CNT_W]   ? '1 : le_sum[CNT_W-1:0];
    assign avg_add  = avg_sum[SUM_W]  ? '1 : avg_sum[SUM_W-1:0];
    assign peak_add = peak_sum[SUM_W] ? '1 : peak_sum[SUM_W-1:0];

    assign prod    = PROD_W'(le_reg) * PROD_W'(lat_reg);
    assign cand    = div_ovf ? '1 : div_quo;
    assign le_zero = le_reg == '0;

    always_comb
    begin
        last_next = last_reg;
        ev_next   = ev_reg;
        le_next   = le_reg;
        avg_next  = avg_reg;
        peak_next = peak_reg;
        if (cmd.time_update)
        begin
            last_next = now_reg;
            if (stale)
            begin
                ev_next   = '0;
                le_next   = '0;
                avg_next  = '0;
                peak_next = '0;
            end
        end
        else if (cmd.decay_step)
        begin
            ev_next   = ev_reg - ev_round[CNT_W+1:2];
            le_next   = le_reg - le_round[CNT_W+1:2];
            avg_next  = avg_reg - (avg_reg >> 2);
            peak_next = peak_reg - (peak_reg >> 2);
        end
        else if (cmd.add_samples)
        begin
            ev_next   = ev_add;
            le_next   = le_add;
            avg_next  = avg_add;
            peak_next = peak_add;
        end
        else if (cmd.take_div && (cmd.div_sel == DIV_CAND) && (peak_reg < cand))
        begin
            peak_next = cand;
        end
    end

    always_comb
    begin
        steps_next = steps_reg;
        if (cmd.time_update)
        begin
            steps_next = (stale || same_time) ? '0 : diff_s[STEP_W-1:0];
        end
        else if (cmd.decay_step)
        begin
            steps_next = steps_reg - STEP_W'(1);
        end
    end

    // Divider operands: the peak candidate, or a sum over events times four.
    always_comb
    begin
        case (cmd.div_sel)
            DIV_CAND:
            begin
                div_num  = {prod_reg, 2'b00};
                div_den  = DEN_W'({count_reg, {QUO_W{1'b0}}});
                div_bits = CAND_BITS;
            end
            DIV_AVG:
            begin
                div_num  = NUM_W'(avg_reg);
                div_den  = DEN_W'({le_reg, 2'b00, {AVG_W{1'b0}}});
                div_bits = RATIO_BITS;
            end
            DIV_PEAK:
            begin
                div_num  = NUM_W'(peak_reg);
                div_den  = DEN_W'({le_reg, 2'b00, {AVG_W{1'b0}}});
                div_bits = RATIO_BITS;
            end
            default:
            begin
                div_num  = '0;
                div_den  = '1;
                div_bits = RATIO_BITS;
            end
        endcase
    end

    llm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .nbits (div_bits),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    // A quotient that overflows the result width is above any 20-bit target.
    assign avg_res   = le_zero ? '0 : (avg_ovf_reg ? '1 : avg_q_reg);
    assign peak_res  = le_zero ? '0 : (peak_ovf_reg ? '1 : peak_q_reg);
    assign over_avg  = !le_zero && (cfg.target_avg != '0)
                       && (avg_ovf_reg || (avg_q_reg > AVG_W'(cfg.target_avg)));
    assign over_peak = !le_zero && (cfg.target_peak != '0)
                       && (peak_ovf_reg || (peak_q_reg > AVG_W'(cfg.target_peak)));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            ev_reg        <= '0;
            le_reg        <= '0;
            avg_reg       <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_reg      <= last_next;
            ev_reg        <= ev_next;
            le_reg        <= le_next;
            avg_reg       <= avg_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= in_ch.kind;
            now_reg   <= in_ch.now_s;
            count_reg <= in_ch.sample_count;
            lat_reg   <= in_ch.latency_ms;
        end
        steps_reg <= steps_next;
        if (cmd.mul)
        begin
            prod_reg <= prod;
        end
        if (cmd.take_div && (cmd.div_sel == DIV_AVG))
        begin
            avg_q_reg   <= div_quo[AVG_W-1:0];
            avg_ovf_reg <= div_ovf;
        end
        if (cmd.take_div && (cmd.div_sel == DIV_PEAK))
        begin
            peak_q_reg   <= div_quo[AVG_W-1:0];
            peak_ovf_reg <= div_ovf;
        end
        if (cmd.load_out)
        begin
            rate_reg     <= RATE_W'(ev_reg >> 2);
            avg_out_reg  <= avg_res;
            peak_out_reg <= peak_res;
            over_reg     <= over_avg | over_peak;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.rate            = rate_reg;
    assign out_ch.avg_latency_ms  = avg_out_reg;
    assign out_ch.peak_latency_ms = peak_out_reg;
    assign out_ch.overloaded      = over_reg;

    assign sts.in_valid   = in_ch.valid;
    assign sts.kind       = kind_reg;
    assign sts.steps_zero = steps_reg == '0;
    assign sts.count_zero = count_reg == '0;
    assign sts.le_zero    = le_zero;
    assign sts.div_done   = div_done;
    assign sts.out_free   = !out_valid_reg || out_ch.ready;

endmodule

`default_nettype wire

// ----- sv/llm_ctrl.sv -----
`default_nettype none

module llm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire llm_pkg::llm_sts_t sts,
    output llm_pkg::llm_cmd_t      cmd
);
    import llm_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_TIME      = 12'b0000_0000_0010,
        ST_DECAY     = 12'b0000_0000_0100,
        ST_ADD       = 12'b0000_0000_1000,
        ST_MUL       = 12'b0000_0001_0000,
        ST_CAND_GO   = 12'b0000_0010_0000,
        ST_CAND_WAIT = 12'b0000_0100_0000,
        ST_AVG_GO    = 12'b0000_1000_0000,
        ST_AVG_WAIT  = 12'b0001_0000_0000,
        ST_PEAK_GO   = 12'b0010_0000_0000,
        ST_PEAK_WAIT = 12'b0100_0000_0000,
        ST_FINISH    = 12'b1000_0000_0000
    } llm_state_t;

    llm_state_t state_reg;
    llm_state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = DIV_CAND;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    state_next = ST_TIME;
                end
            end
            ST_TIME:
            begin
                cmd.time_update = 1'b1;
                state_next      = ST_DECAY;
            end
            ST_DECAY:
            begin
                if (sts.steps_zero)
                begin
                    state_next = (sts.kind == KIND_SAMPLE) ? ST_ADD : ST_AVG_GO;
                end
                else
                begin
                    cmd.decay_step = 1'b1;
                end
            end
            ST_ADD:
            begin
                cmd.add_samples = 1'b1;
                state_next      = sts.count_zero ? ST_AVG_GO : ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_CAND_GO;
            end
            ST_CAND_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_CAND_WAIT;
            end
            ST_CAND_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.take_div = 1'b1;
                    state_next   = ST_AVG_GO;
                end
            end
            ST_AVG_GO:
            begin
                cmd.div_sel = DIV_AVG;
                if (sts.le_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_AVG_WAIT;
                end
            end
            ST_AVG_WAIT:
            begin
                cmd.div_sel = DIV_AVG;
                if (sts.div_done)
                begin
                    cmd.take_div = 1'b1;
                    state_next   = ST_PEAK_GO;
                end
            end
            ST_PEAK_GO:
            begin
                cmd.div_sel   = DIV_PEAK;
                cmd.div_start = 1'b1;
                state_next    = ST_PEAK_WAIT;
            end
            ST_PEAK_WAIT:
            begin
                cmd.div_sel = DIV_PEAK;
                if (sts.div_done)
                begin
                    cmd.take_div = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Wait here while the previous result has not been taken.
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/latency_load_monitor_top.sv -----
// Channel   Direction  Payload                                           Handshake
// in_ch     sink       kind, now_s, sample_count, latency_ms             valid/ready
// out_ch    source     rate, avg_latency_ms, peak_latency_ms, overloaded  valid/ready
// APB       slave      target_avg_ms at 0x0, target_peak_ms at 0x4       psel/penable
//
// One item at a time; with s decay seconds (s <= 8) the totals are decayed s times,
// then a sample adds its counts and, for a nonzero count, divides out a peak
// candidate; the average and peak are then divided by four times the event count,
// one quotient bit per cycle. An overflowing division ends early; with no events
// left both divisions are skipped. rst_n clears totals, targets and control; a
// stalled result holds the block in its last step until the output register is free.
`default_nettype none

module latency_load_monitor_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [llm_pkg::APB_AW-1:0] paddr,
    input  wire logic [llm_pkg::APB_DW-1:0] pwdata,
    output logic      [llm_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    llm_in_if.sink                          in_ch,
    llm_out_if.source                       out_ch
);
    import llm_pkg::*;

    llm_cfg_t cfg;
    llm_cmd_t cmd;
    llm_sts_t sts;

    llm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    llm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    llm_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule

`default_nettype wire

// ----- sv/llm_checker.sv -----
`default_nettype none

module llm_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [llm_pkg::RATE_W-1:0] rate,
    input wire logic [llm_pkg::AVG_W-1:0]  avg_latency_ms,
    input wire logic [llm_pkg::AVG_W-1:0]  peak_latency_ms,
    input wire logic                       overloaded
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(rate) && $stable(avg_latency_ms)
                                    && $stable(peak_latency_ms) && $stable(overloaded))
        else $error("result changed while stalled");

    // Only one item is in work, so no second transfer follows directly.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on the cycle after a transfer");

    // No result appears directly after an input transfer.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared the cycle after an input transfer");

endmodule

bind latency_load_monitor_top llm_checker u_llm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .rate            (out_ch.rate),
    .avg_latency_ms  (out_ch.avg_latency_ms),
    .peak_latency_ms (out_ch.peak_latency_ms),
    .overloaded      (out_ch.overloaded)
);

`default_nettype wire
